// ----- rtl/core/fcte_pkg.sv -----
`timescale 1ns / 1ps

package fcte_pkg;

  // Field widths fixed by the port list
  localparam int CMD_W = 3;
  localparam int IDX_W = 12;
  localparam int VAL_W = 16;
  localparam int ST_W  = 3;

  // Commands
  localparam logic [CMD_W-1:0] CMD_FORMAT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_ENTRY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_DONE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_FREE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_USED   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_WALK_CHAIN = 3'd6;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_LOADED = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_FREE    = 3'd2;
  localparam logic [ST_W-1:0] ST_OCCUPIED   = 3'd3;
  localparam logic [ST_W-1:0] ST_TRUNCATED  = 3'd4;
  localparam logic [ST_W-1:0] ST_BAD_LINK   = 3'd5;

  // Link values
  localparam logic [VAL_W-1:0] LINK_FREE  = 16'h0000;
  localparam logic [VAL_W-1:0] LINK_MEDIA = 16'hfffd;
  localparam logic [VAL_W-1:0] LINK_RSVD  = 16'hfffe;
  localparam logic [VAL_W-1:0] LINK_END   = 16'hffff;

  // Write port source
  localparam logic [2:0] WR_NONE  = 3'd0;
  localparam logic [2:0] WR_INPUT = 3'd1;
  localparam logic [2:0] WR_FREE  = 3'd2;
  localparam logic [2:0] WR_HELD  = 3'd3;
  localparam logic [2:0] WR_FMT   = 3'd4;

  // Read port address source
  localparam logic [1:0] RD_INPUT    = 2'd0;
  localparam logic [1:0] RD_ZERO     = 2'd1;
  localparam logic [1:0] RD_PTR_NEXT = 2'd2;
  localparam logic [1:0] RD_LINK     = 2'd3;

  // Result index source
  localparam logic [1:0] IX_ZERO  = 2'd0;
  localparam logic [1:0] IX_INPUT = 2'd1;
  localparam logic [1:0] IX_PTR   = 2'd2;
  localparam logic [1:0] IX_CUR   = 2'd3;

  typedef struct packed {
    logic             accept;
    logic             ptr_clr;
    logic             ptr_inc;
    logic [2:0]       wr_sel;
    logic [1:0]       rd_sel;
    logic             walk_start;
    logic             walk_step;
    logic             set_loaded;
    logic             emit;
    logic [ST_W-1:0]  emit_status;
    logic             emit_last;
    logic [1:0]       ix_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic loaded;
    logic idx_ok;
    logic rd_zero;
    logic rd_end;
    logic rd_link_ok;
    logic ptr_last;
    logic n_last;
  } dp_sts_t;

  // Value laid down by format at a given entry
  function automatic logic [VAL_W-1:0] fmt_value(input logic [15:0] addr);
    logic [VAL_W-1:0] v;
    if (addr == 16'd0) begin
      v = LINK_MEDIA;
    end else if (addr <= 16'd8) begin
      v = LINK_RSVD;
    end else if (addr == 16'd9) begin
      v = LINK_END;
    end else begin
      v = LINK_FREE;
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/fcte_datapath.sv -----
`timescale 1ns / 1ps

module fcte_datapath #(
  parameter int NUM_CLUSTERS = 4096,
  parameter int MAX_CHAIN    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fcte_pkg::IDX_W-1:0]    in_cluster_index,
  input  logic [fcte_pkg::VAL_W-1:0]    in_entry_value,
  input  fcte_pkg::dp_cmd_t             cmd,
  output fcte_pkg::dp_sts_t             sts,
  output logic                          out_valid,
  output logic [fcte_pkg::ST_W-1:0]     out_status,
  output logic [fcte_pkg::IDX_W-1:0]    out_result_index,
  output logic                          out_last
);

  localparam int AW = $clog2(NUM_CLUSTERS);
  localparam int CW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam logic [16:0] NUM_C = 17'(NUM_CLUSTERS);
  localparam logic [AW-1:0] PTR_LAST = AW'(NUM_CLUSTERS - 1);
  localparam logic [CW-1:0] N_LAST = CW'(MAX_CHAIN - 1);

  logic [fcte_pkg::VAL_W-1:0] mem [NUM_CLUSTERS];

  logic [fcte_pkg::VAL_W-1:0] rd_data_r;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [fcte_pkg::VAL_W-1:0] wr_data;

  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [AW-1:0]              cur_r, cur_nxt;
  logic [CW-1:0]              n_r, n_nxt;
  logic [AW-1:0]              held_idx_r;
  logic [fcte_pkg::VAL_W-1:0] held_val_r;
  logic                       loaded_r;

  logic                       out_valid_r;
  logic [fcte_pkg::ST_W-1:0]  out_status_r;
  logic [fcte_pkg::IDX_W-1:0] out_index_r, out_index_nxt;
  logic                       out_last_r;

  always_comb begin
    case (cmd.rd_sel)
      fcte_pkg::RD_INPUT:    rd_addr = AW'(in_cluster_index);
      fcte_pkg::RD_ZERO:     rd_addr = '0;
      fcte_pkg::RD_PTR_NEXT: rd_addr = AW'(ptr_r + 1'b1);
      fcte_pkg::RD_LINK:     rd_addr = rd_data_r[AW-1:0];
      default:               rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = AW'(in_cluster_index);
    wr_data = in_entry_value;
    case (cmd.wr_sel)
      fcte_pkg::WR_INPUT: ;
      fcte_pkg::WR_FREE:  wr_data = fcte_pkg::LINK_FREE;
      fcte_pkg::WR_HELD: begin
        wr_addr = held_idx_r;
        wr_data = held_val_r;
      end
      fcte_pkg::WR_FMT: begin
        wr_addr = ptr_r;
        wr_data = fcte_pkg::fmt_value(16'(ptr_r));
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = AW'(ptr_r + 1'b1);
    end
    cur_nxt = cur_r;
    n_nxt   = n_r;
    if (cmd.walk_start) begin
      cur_nxt = AW'(in_cluster_index);
      n_nxt   = '0;
    end else if (cmd.walk_step) begin
      cur_nxt = rd_data_r[AW-1:0];
      n_nxt   = CW'(n_r + 1'b1);
    end
  end

  always_comb begin
    case (cmd.ix_sel)
      fcte_pkg::IX_ZERO:  out_index_nxt = '0;
      fcte_pkg::IX_INPUT: out_index_nxt = in_cluster_index;
      fcte_pkg::IX_PTR:   out_index_nxt = fcte_pkg::IDX_W'(ptr_r);
      fcte_pkg::IX_CUR:   out_index_nxt = fcte_pkg::IDX_W'(cur_r);
      default:            out_index_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    cur_r <= cur_nxt;
    n_r   <= n_nxt;
    if (cmd.accept) begin
      held_idx_r <= AW'(in_cluster_index);
      held_val_r <= in_entry_value;
    end
    out_status_r <= cmd.emit_status;
    out_index_r  <= out_index_nxt;
    out_last_r   <= cmd.emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.set_loaded) begin
        loaded_r <= 1'b1;
      end
      out_valid_r <= cmd.emit;
    end
  end

  assign sts.loaded     = loaded_r;
  assign sts.idx_ok     = (17'(in_cluster_index) < NUM_C);
  assign sts.rd_zero    = (rd_data_r == fcte_pkg::LINK_FREE);
  assign sts.rd_end     = (rd_data_r == fcte_pkg::LINK_END);
  assign sts.rd_link_ok = (17'(rd_data_r) < NUM_C);
  assign sts.ptr_last   = (ptr_r == PTR_LAST);
  assign sts.n_last     = (n_r == N_LAST);

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_index = out_index_r;
  assign out_last         = out_last_r;

endmodule

// ----- rtl/core/fcte_ctrl.sv -----
`timescale 1ns / 1ps

module fcte_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fcte_pkg::CMD_W-1:0]  in_command,
  input  fcte_pkg::dp_sts_t           sts,
  output fcte_pkg::dp_cmd_t           cmd,
  output logic                        busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FMT  = 3'd1;
  localparam logic [2:0] S_FIND = 3'd2;
  localparam logic [2:0] S_SET  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd         = '0;
    cmd.wr_sel  = fcte_pkg::WR_NONE;
    cmd.rd_sel  = fcte_pkg::RD_INPUT;
    cmd.ix_sel  = fcte_pkg::IX_ZERO;
    cmd.emit_status = fcte_pkg::ST_OK;
    state_nxt   = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (in_command)
            fcte_pkg::CMD_FORMAT: begin
              cmd.ptr_clr = 1'b1;
              state_nxt   = S_FMT;
            end
            fcte_pkg::CMD_LOAD_ENTRY: begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (sts.idx_ok) begin
                cmd.wr_sel = fcte_pkg::WR_INPUT;
              end else begin
                cmd.emit_status = fcte_pkg::ST_BAD_LINK;
              end
            end
            fcte_pkg::CMD_LOAD_DONE: begin
              cmd.set_loaded = 1'b1;
              cmd.emit       = 1'b1;
              cmd.emit_last  = 1'b1;
            end
            fcte_pkg::CMD_FIND_FREE: begin
              if (!sts.loaded) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = fcte_pkg::ST_NOT_LOADED;
              end else begin
                cmd.rd_sel  = fcte_pkg::RD_ZERO;
                cmd.ptr_clr = 1'b1;
                state_nxt   = S_FIND;
              end
            end
            fcte_pkg::CMD_SET_USED, fcte_pkg::CMD_CLEAR: begin
              if (!sts.loaded) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = fcte_pkg::ST_NOT_LOADED;
              end else if (!sts.idx_ok) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = fcte_pkg::ST_BAD_LINK;
              end else if (in_command == fcte_pkg::CMD_CLEAR) begin
                cmd.wr_sel    = fcte_pkg::WR_FREE;
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
              end else begin
                state_nxt = S_SET;
              end
            end
            fcte_pkg::CMD_WALK_CHAIN: begin
              if (!sts.loaded) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = fcte_pkg::ST_NOT_LOADED;
              end else if (!sts.idx_ok) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = fcte_pkg::ST_BAD_LINK;
                cmd.ix_sel      = fcte_pkg::IX_INPUT;
              end else begin
                cmd.walk_start = 1'b1;
                state_nxt      = S_WALK;
              end
            end
            default: begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
            end
          endcase
        end
      end
      S_FMT: begin
        cmd.wr_sel = fcte_pkg::WR_FMT;
        if (sts.ptr_last) begin
          cmd.set_loaded = 1'b1;
          cmd.emit       = 1'b1;
          cmd.emit_last  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_FIND: begin
        if (sts.rd_zero) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.ix_sel    = fcte_pkg::IX_PTR;
          state_nxt     = S_IDLE;
        end else if (sts.ptr_last) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = fcte_pkg::ST_NO_FREE;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd_sel  = fcte_pkg::RD_PTR_NEXT;
          cmd.ptr_inc = 1'b1;
        end
      end
      S_SET: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        state_nxt     = S_IDLE;
        if (sts.rd_zero) begin
          cmd.wr_sel = fcte_pkg::WR_HELD;
        end else begin
          cmd.emit_status = fcte_pkg::ST_OCCUPIED;
        end
      end
      S_WALK: begin
        cmd.emit   = 1'b1;
        cmd.ix_sel = fcte_pkg::IX_CUR;
        if (sts.rd_end) begin
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end else if (!sts.rd_link_ok) begin
          cmd.emit_last   = 1'b1;
          cmd.emit_status = fcte_pkg::ST_BAD_LINK;
          state_nxt       = S_IDLE;
        end else if (sts.n_last) begin
          cmd.emit_last   = 1'b1;
          cmd.emit_status = fcte_pkg::ST_TRUNCATED;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd_sel    = fcte_pkg::RD_LINK;
          cmd.walk_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- rtl/core/fat_cluster_table_engine.sv -----
`timescale 1ns / 1ps

// Cluster allocation table engine. A command is taken on a clock edge with
// start high and busy low; every result appears on out_* for exactly one
// cycle with out_valid high, and the receiver must take it then, as there is
// no way to hold results off. Load entry, load done, clear, unknown codes and
// any refused command (table not loaded, index out of range) answer in the
// cycle after the transfer and leave busy low, so a new command may follow at
// once. Set used reads its entry first, checks it in the set state and then
// answers. Find free scans the table through the single read port, one entry
// per cycle, and answers on the first free entry or after the last entry.
// Format sweeps the write port over every entry, one per cycle, and answers
// once the last entry is written. Walk chain follows links through the read
// port and emits one result per cycle on consecutive cycles, the first once
// the start entry is read and the walk state entered, at most MAX_CHAIN of
// them; out_last marks the final one. Table contents are undefined after
// reset until format or load entry writes them.
module fat_cluster_table_engine #(
  parameter int NUM_CLUSTERS = 4096,
  parameter int MAX_CHAIN    = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [fcte_pkg::CMD_W-1:0]  in_command,
  input  logic [fcte_pkg::IDX_W-1:0]  in_cluster_index,
  input  logic [fcte_pkg::VAL_W-1:0]  in_entry_value,
  output logic                        out_valid,
  output logic [fcte_pkg::ST_W-1:0]   out_status,
  output logic [fcte_pkg::IDX_W-1:0]  out_result_index,
  output logic                        out_last
);

  fcte_pkg::dp_cmd_t dp_cmd;
  fcte_pkg::dp_sts_t dp_sts;

  // Sequencer: decodes each command and steps the sweep, scan and walk loops
  fcte_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (dp_sts),
    .cmd        (dp_cmd),
    .busy       (busy)
  );

  // Table memory, scan pointer, chain cursor and the result register
  fcte_datapath #(
    .NUM_CLUSTERS (NUM_CLUSTERS),
    .MAX_CHAIN    (MAX_CHAIN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cluster_index (in_cluster_index),
    .in_entry_value   (in_entry_value),
    .cmd              (dp_cmd),
    .sts              (dp_sts),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_index (out_result_index),
    .out_last         (out_last)
  );

  // A command that goes busy must end with a final result transfer
  a_busy_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_valid && out_last))
    else $error("busy dropped without a final result");

  // Every accepted command answers at once or starts a multi-cycle operation
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted command neither answered nor went busy");

  // Chain results come on consecutive cycles until the last one
  a_chain_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a chain walk");

  // Intermediate chain results always carry ok status
  a_mid_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == fcte_pkg::ST_OK))
    else $error("non-final result with error status");

endmodule
